>>> rtl/core/grid_ray_walker_unit_defines.svh
// ---------------------------------------------------------------------------
// Grid ray walker assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef GRID_RAY_WALKER_UNIT_DEFINES_SVH
`define GRID_RAY_WALKER_UNIT_DEFINES_SVH

// same-cycle implication
`define GRW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/grw_pkg.sv
// ---------------------------------------------------------------------------
// Grid ray walker package
// Request and result types, register and status codes, trig table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package grw_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int TRIG_W      = 18;

  localparam logic [1:0] CFG_CELL_RES = 2'd0;
  localparam logic [1:0] CFG_MAP_W    = 2'd1;
  localparam logic [1:0] CFG_TEX_SIZE = 2'd2;

  localparam logic [1:0] STAT_WALL  = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_LEFT  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  localparam longint SIN_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};
  localparam longint COS_DIV [9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

  typedef struct packed {
    logic        func;
    logic [11:0] map_addr;
    logic [15:0] map_value;
    logic [23:0] start_x;
    logic [23:0] start_y;
    logic [5:0]  start_map_x;
    logic [5:0]  start_map_y;
    logic [8:0]  ray_angle;
    logic [8:0]  view_offset;
    logic [11:0] column;
  } grw_req_t;

  typedef struct packed {
    logic [11:0] column_out;
    logic [15:0] wall_value;
    logic [23:0] distance;
    logic [5:0]  hit_map_x;
    logic [5:0]  hit_map_y;
    logic [5:0]  last_map_x;
    logic [5:0]  last_map_y;
    logic [7:0]  texel_x;
    logic [7:0]  texel_y;
    logic [1:0]  status;
  } grw_rsp_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

  function automatic longint grw_mul_q30(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = (a < 0) ? longint'(-a) : longint'(a);
    mb = (b < 0) ? longint'(-b) : longint'(b);
    p  = (ma * mb + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic trig_tab_t grw_trig_tab(input bit want_sin);
    trig_tab_t      tab;
    longint         y;
    longint         y2;
    longint         st;
    longint         ct;
    longint         s;
    longint         c;
    longint         s2;
    longint         c2;
    longint         v;
    longint unsigned m;
    for (int d = 0; d < ANGLE_STEPS; d++) begin
      y  = ((longint'(d) * 314) * (longint'(1) << 30) + 72000) / 144000;
      y2 = grw_mul_q30(y, y);
      st = y;
      ct = longint'(1) << 30;
      s  = 0;
      c  = 0;
      for (int k = 0; k < 9; k++) begin
        if ((k & 1) == 1) begin
          s = s - st;
          c = c - ct;
        end else begin
          s = s + st;
          c = c + ct;
        end
        st = grw_mul_q30(st, y2) / SIN_DIV[k];
        ct = grw_mul_q30(ct, y2) / COS_DIV[k];
      end
      for (int k = 0; k < 3; k++) begin
        s2 = 2 * grw_mul_q30(s, c);
        c2 = grw_mul_q30(c, c) - grw_mul_q30(s, s);
        s  = s2;
        c  = c2;
      end
      v = want_sin ? s : c;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + 64'd8192) >> 14;
      tab[d] = (v < 0) ? TRIG_W'(-longint'(m)) : TRIG_W'(longint'(m));
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/grid_ray_walker_unit.sv
// ---------------------------------------------------------------------------
// Grid ray walker unit
// Map memory plus a grid ray walker with distance and texel computation.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_req_i  (grw_req_t)
//   out      out  out_valid_o / out_ready_i out_rsp_o (grw_rsp_t)
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A ray does the trig lookup, then walks plain steps and cell crossings (map
// read), then squares, square root and scaling, then bit-serial remainder for
// the texels. The walk loop and the shared multiplier, root and remainder
// sequencer carry out these steps. Reset is asynchronous; map contents are
// undefined until written. The result waits in the output register while the
// next request is accepted.
// ---------------------------------------------------------------------------
`default_nettype none
`include "grid_ray_walker_unit_defines.svh"

module grid_ray_walker_unit
  import grw_pkg::*;
#(
  parameter int MAP_SIDE  = 64,
  parameter int MAX_STEPS = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire grw_req_t  in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output grw_rsp_t       out_rsp_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i
);

  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int SIDE_LG   = $clog2(MAP_SIDE);
  localparam int IW        = ((SIDE_LG > 6) ? SIDE_LG : 6) + 2;
  localparam int AXW       = IW + 7;
  localparam int WAW       = AW + 12;
  localparam int SW        = $clog2(MAX_STEPS + 1);
  localparam int POS_W     = 27;
  localparam int TR_W      = 28 + $clog2(MAX_STEPS);
  localparam int SUM_W     = TR_W + 1;
  localparam int WH_W      = SUM_W - 16;
  localparam int MC_W      = $clog2(WH_W);

  localparam trig_tab_t COS_TAB = grw_trig_tab(1'b0);
  localparam trig_tab_t SIN_TAB = grw_trig_tab(1'b1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_STEP, ST_PROBE, ST_CELL, ST_FIN, ST_SQX, ST_SQY,
    ST_ROOT, ST_SCALE, ST_MODX, ST_MODY, ST_DONE
  } state_e;

  state_e state_q;

  logic [8:0] cell_res_q;
  logic [6:0] map_w_q;
  logic [8:0] tex_size_q;

  logic [15:0] map_mem [MAP_DEPTH];
  logic [15:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic [WAW-1:0] wr_addr_w;

  logic [8:0] ang_q;
  logic [8:0] vo_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cosv_q;

  logic [11:0] column_q;
  logic [23:0] sx_q;
  logic [23:0] sy_q;
  logic signed [POS_W-1:0] r1_q;
  logic signed [POS_W-1:0] cx_q;
  logic signed [POS_W-1:0] cy_q;
  logic signed [TR_W-1:0]  ax_q;
  logic signed [TR_W-1:0]  ay_q;
  logic signed [IW-1:0]    mx_q;
  logic signed [IW-1:0]    my_q;
  logic [SW-1:0]           step_cnt_q;

  logic signed [IW-1:0]    nmx_q;
  logic signed [IW-1:0]    nmy_q;
  logic signed [POS_W-1:0] wx_q;
  logic signed [POS_W-1:0] wy_q;
  logic signed [POS_W-1:0] ex_q;
  logic signed [POS_W-1:0] ey_q;
  logic signed [POS_W-1:0] dx_q;
  logic signed [POS_W-1:0] dy_q;
  logic                    xo_q;
  logic                    yo_q;

  logic [15:0] wall_q;
  logic [5:0]  hx_q;
  logic [5:0]  hy_q;
  logic [1:0]  status_q;

  logic [30:0]     mxa_q;
  logic [30:0]     mya_q;
  logic [WH_W-1:0] whole_x_q;
  logic [WH_W-1:0] whole_y_q;
  logic [63:0]     acc_q;
  logic [63:0]     root_q;
  logic [63:0]     root_bit_q;
  logic [23:0]     dist_q;
  logic [9:0]      rem_q;
  logic [MC_W-1:0] mod_cnt_q;
  logic [7:0]      texel_x_q;
  logic [7:0]      texel_y_q;

  logic     out_valid_q;
  grw_rsp_t out_rsp_q;

  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic                    xo;
  logic                    yo;
  logic signed [POS_W-1:0] wx;
  logic signed [POS_W-1:0] wy;
  logic signed [POS_W-1:0] ex;
  logic signed [POS_W-1:0] ey;
  logic signed [POS_W-1:0] dx;
  logic signed [POS_W-1:0] dy;
  logic signed [IW-1:0]    nmx;
  logic signed [IW-1:0]    nmy;
  logic signed [TR_W-1:0]  ix_t;
  logic signed [TR_W-1:0]  iy_t;
  logic signed [TR_W-1:0]  stop_ax;
  logic signed [TR_W-1:0]  stop_ay;
  logic signed [TR_W-1:0]  go_ax;
  logic signed [TR_W-1:0]  go_ay;
  logic [AXW-1:0]          probe_addr;
  logic                    probe_ok;
  logic [TR_W-1:0]         mag_ax;
  logic [TR_W-1:0]         mag_ay;
  logic [TR_W-1:0]         shr_ax;
  logic [TR_W-1:0]         shr_ay;
  logic signed [SUM_W-1:0] pos_x;
  logic signed [SUM_W-1:0] pos_y;
  logic [SUM_W-1:0]        mag_px;
  logic [SUM_W-1:0]        mag_py;
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_p;
  logic [63:0]             root_try;
  logic [63:0]             scale_w;
  logic [9:0]              rem_n;
  logic [9:0]              rem_r;
  logic [8:0]              cr_eff;
  logic [8:0]              ang_red;
  logic [8:0]              vo_red;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign wr_addr_w = WAW'(in_req_i.map_addr);
  assign rd_addr   = probe_addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o && (in_req_i.func == FUNC_WRITE) &&
        (32'(in_req_i.map_addr) < MAP_DEPTH)) begin
      map_mem[wr_addr_w[AW-1:0]] <= in_req_i.map_value;
    end
    rdata_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= COS_TAB[ang_q];
    sin_q  <= SIN_TAB[ang_q];
    cosv_q <= COS_TAB[vo_q];
  end

  always_comb begin
    cr_eff  = (cell_res_q < 9'd2) ? 9'd2 : cell_res_q;
    ang_red = (in_req_i.ray_angle >= 9'(ANGLE_STEPS)) ?
              in_req_i.ray_angle - 9'(ANGLE_STEPS) : in_req_i.ray_angle;
    vo_red  = (in_req_i.view_offset >= 9'(ANGLE_STEPS)) ?
              in_req_i.view_offset - 9'(ANGLE_STEPS) : in_req_i.view_offset;

    ix_t = TR_W'(cos_q);
    iy_t = TR_W'(sin_q);
    nx   = cx_q + POS_W'(cos_q);
    ny   = cy_q + POS_W'(sin_q);
    xo   = (nx < 0) || (nx > r1_q);
    yo   = (ny < 0) || (ny > r1_q);
    wx   = nx;
    wy   = ny;
    ex   = '0;
    ey   = '0;
    dx   = '0;
    dy   = '0;
    nmx  = mx_q;
    nmy  = my_q;
    if (xo) begin
      if (nx < 0) begin
        wx  = nx + r1_q;
        nmx = mx_q - IW'(1);
        ex  = cx_q;
        dx  = r1_q - wx;
      end else begin
        wx  = nx - r1_q;
        nmx = mx_q + IW'(1);
        ex  = r1_q - cx_q;
        dx  = wx;
      end
    end
    if (yo) begin
      if (ny < 0) begin
        wy  = ny + r1_q;
        nmy = my_q - IW'(1);
        ey  = cy_q;
        dy  = r1_q - wy;
      end else begin
        wy  = ny - r1_q;
        nmy = my_q + IW'(1);
        ey  = r1_q - cy_q;
        dy  = wy;
      end
    end

    stop_ax = ax_q + (xo_q ? TR_W'(ex_q) : ix_t);
    stop_ay = ay_q + (yo_q ? TR_W'(ey_q) : iy_t);
    go_ax   = ax_q + (xo_q ? TR_W'(dx_q) + TR_W'(ex_q) : ix_t);
    go_ay   = ay_q + (yo_q ? TR_W'(dy_q) + TR_W'(ey_q) : iy_t);

    probe_addr = AXW'(unsigned'(nmx_q[IW-2:0])) +
                 AXW'(unsigned'(nmy_q[IW-2:0])) * AXW'(map_w_q);
    probe_ok   = !nmx_q[IW-1] && !nmy_q[IW-1] &&
                 (32'(unsigned'(nmx_q[IW-2:0])) < 32'(map_w_q)) &&
                 (32'(unsigned'(nmy_q[IW-2:0])) < MAP_SIDE) &&
                 (32'(probe_addr) < MAP_DEPTH);

    mag_ax = ax_q[TR_W-1] ? TR_W'(-ax_q) : TR_W'(ax_q);
    mag_ay = ay_q[TR_W-1] ? TR_W'(-ay_q) : TR_W'(ay_q);
    shr_ax = mag_ax >> 8;
    shr_ay = mag_ay >> 8;
    pos_x  = SUM_W'(ax_q) + SUM_W'({1'b0, sx_q});
    pos_y  = SUM_W'(ay_q) + SUM_W'({1'b0, sy_q});
    mag_px = pos_x[SUM_W-1] ? SUM_W'(-pos_x) : SUM_W'(pos_x);
    mag_py = pos_y[SUM_W-1] ? SUM_W'(-pos_y) : SUM_W'(pos_y);

    unique case (state_q)
      ST_SQX: begin
        mul_a = 32'(mxa_q);
        mul_b = 32'(mxa_q);
      end
      ST_SQY: begin
        mul_a = 32'(mya_q);
        mul_b = 32'(mya_q);
      end
      default: begin
        mul_a = root_q[31:0];
        mul_b = cosv_q[TRIG_W-1] ? 32'(-cosv_q) : 32'(cosv_q);
      end
    endcase
    mul_p    = 64'(mul_a) * 64'(mul_b);
    root_try = root_q + root_bit_q;
    scale_w  = (mul_p + 64'd32768) >> 16;

    rem_n = {rem_q[8:0], (state_q == ST_MODY) ? whole_y_q[mod_cnt_q]
                                              : whole_x_q[mod_cnt_q]};
    rem_r = (rem_n >= {1'b0, tex_size_q}) ? rem_n - {1'b0, tex_size_q} : rem_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cell_res_q  <= 9'd64;
      map_w_q     <= 7'd64;
      tex_size_q  <= 9'd64;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      ang_q       <= '0;
      vo_q        <= '0;
      column_q    <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      r1_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      step_cnt_q  <= '0;
      nmx_q       <= '0;
      nmy_q       <= '0;
      wx_q        <= '0;
      wy_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      xo_q        <= 1'b0;
      yo_q        <= 1'b0;
      wall_q      <= '0;
      hx_q        <= '0;
      hy_q        <= '0;
      status_q    <= STAT_LIMIT;
      mxa_q       <= '0;
      mya_q       <= '0;
      whole_x_q   <= '0;
      whole_y_q   <= '0;
      acc_q       <= '0;
      root_q      <= '0;
      root_bit_q  <= '0;
      dist_q      <= '0;
      rem_q       <= '0;
      mod_cnt_q   <= '0;
      texel_x_q   <= '0;
      texel_y_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CELL_RES: cell_res_q <= cfg_data_i;
          CFG_MAP_W:    map_w_q    <= cfg_data_i[6:0];
          CFG_TEX_SIZE: tex_size_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (in_req_i.func == FUNC_CAST)) begin
            ang_q      <= ang_red;
            vo_q       <= vo_red;
            column_q   <= in_req_i.column;
            sx_q       <= in_req_i.start_x;
            sy_q       <= in_req_i.start_y;
            cx_q       <= POS_W'({1'b0, in_req_i.start_x});
            cy_q       <= POS_W'({1'b0, in_req_i.start_y});
            r1_q       <= POS_W'({1'b0, cr_eff - 9'd1, 16'd0});
            mx_q       <= IW'(in_req_i.start_map_x);
            my_q       <= IW'(in_req_i.start_map_y);
            ax_q       <= '0;
            ay_q       <= '0;
            step_cnt_q <= '0;
            wall_q     <= '0;
            hx_q       <= '0;
            hy_q       <= '0;
            status_q   <= STAT_LIMIT;
            state_q    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          if (step_cnt_q == SW'(MAX_STEPS)) begin
            state_q <= ST_FIN;
          end else begin
            step_cnt_q <= step_cnt_q + SW'(1);
            if (!xo && !yo) begin
              ax_q <= ax_q + ix_t;
              ay_q <= ay_q + iy_t;
              cx_q <= nx;
              cy_q <= ny;
            end else begin
              nmx_q   <= nmx;
              nmy_q   <= nmy;
              wx_q    <= wx;
              wy_q    <= wy;
              ex_q    <= ex;
              ey_q    <= ey;
              dx_q    <= dx;
              dy_q    <= dy;
              xo_q    <= xo;
              yo_q    <= yo;
              state_q <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (!probe_ok) begin
            ax_q     <= stop_ax;
            ay_q     <= stop_ay;
            status_q <= STAT_LEFT;
            state_q  <= ST_FIN;
          end else begin
            state_q <= ST_CELL;
          end
        end
        ST_CELL: begin
          if (rdata_q == 16'd0) begin
            mx_q    <= nmx_q;
            my_q    <= nmy_q;
            ax_q    <= go_ax;
            ay_q    <= go_ay;
            cx_q    <= wx_q;
            cy_q    <= wy_q;
            state_q <= ST_STEP;
          end else begin
            ax_q     <= stop_ax;
            ay_q     <= stop_ay;
            wall_q   <= rdata_q;
            hx_q     <= nmx_q[5:0];
            hy_q     <= nmy_q[5:0];
            status_q <= STAT_WALL;
            state_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          mxa_q     <= (shr_ax > TR_W'(64'd1 << 30)) ? 31'(64'd1 << 30) : 31'(shr_ax);
          mya_q     <= (shr_ay > TR_W'(64'd1 << 30)) ? 31'(64'd1 << 30) : 31'(shr_ay);
          whole_x_q <= mag_px[SUM_W-1:16];
          whole_y_q <= mag_py[SUM_W-1:16];
          state_q   <= ST_SQX;
        end
        ST_SQX: begin
          acc_q   <= mul_p;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          acc_q      <= acc_q + mul_p;
          root_q     <= '0;
          root_bit_q <= 64'd1 << 62;
          state_q    <= ST_ROOT;
        end
        ST_ROOT: begin
          if (acc_q >= root_try) begin
            acc_q  <= acc_q - root_try;
            root_q <= (root_q >> 1) + root_bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          root_bit_q <= root_bit_q >> 2;
          if (root_bit_q == 64'd1) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          dist_q    <= (scale_w > 64'hFF_FFFF) ? 24'hFF_FFFF : scale_w[23:0];
          rem_q     <= '0;
          mod_cnt_q <= MC_W'(WH_W - 1);
          state_q   <= ST_MODX;
        end
        ST_MODX: begin
          if (mod_cnt_q == '0) begin
            texel_x_q <= (tex_size_q == 9'd0) ? 8'd0 : rem_r[7:0];
            rem_q     <= '0;
            mod_cnt_q <= MC_W'(WH_W - 1);
            state_q   <= ST_MODY;
          end else begin
            rem_q     <= rem_r;
            mod_cnt_q <= mod_cnt_q - MC_W'(1);
          end
        end
        ST_MODY: begin
          if (mod_cnt_q == '0) begin
            texel_y_q <= (tex_size_q == 9'd0) ? 8'd0 : rem_r[7:0];
            state_q   <= ST_DONE;
          end else begin
            rem_q     <= rem_r;
            mod_cnt_q <= mod_cnt_q - MC_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_rsp_q.column_out <= column_q;
            out_rsp_q.wall_value <= wall_q;
            out_rsp_q.distance   <= dist_q;
            out_rsp_q.hit_map_x  <= hx_q;
            out_rsp_q.hit_map_y  <= hy_q;
            out_rsp_q.last_map_x <= mx_q[5:0];
            out_rsp_q.last_map_y <= my_q[5:0];
            out_rsp_q.texel_x    <= texel_x_q;
            out_rsp_q.texel_y    <= texel_y_q;
            out_rsp_q.status     <= status_q;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `GRW_ASSERT_IMP(a_busy_not_ready, state_q != ST_IDLE, !in_ready_o, "ready while busy")
  `GRW_ASSERT_NXT(a_cast_starts, in_valid_i && in_ready_o && in_req_i.func, state_q == ST_LOOK, "cast did not start")
  `GRW_ASSERT_IMP(a_step_bound, 1'b1, step_cnt_q <= SW'(MAX_STEPS), "step count past limit")
  `GRW_ASSERT_IMP(a_root_bit, state_q == ST_ROOT, $onehot(root_bit_q), "root bit lost")

endmodule

`default_nettype wire

>>> dv/grid_ray_walker_unit_checker.sv
// ---------------------------------------------------------------------------
// Grid ray walker checker
// Watches the request, result and register ports, keeps its own copy of the
// map and registers, predicts every ray result at request acceptance and
// compares accepted results field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_ray_walker_unit_checker
  import grw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire grw_req_t   in_req_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire grw_rsp_t   out_rsp_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);

  localparam int MAP_SIDE  = 64;
  localparam int MAX_STEPS = 1024;
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;

  longint      cos_q16 [ANGLE_STEPS];
  longint      sin_q16 [ANGLE_STEPS];
  logic [15:0] map_mem [MAP_DEPTH];
  logic [8:0]  cell_res;
  logic [6:0]  map_w;
  logic [8:0]  tex_size;
  grw_rsp_t    ray_results [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = ray_results.size();

  function automatic longint unsigned mag(input longint a);
    return (a < 0) ? longint'(-a) : longint'(a);
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned p;
    p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] texel_of(input longint travel, input longint start);
    longint unsigned whole;
    whole = mag(travel + start) >> 16;
    if (tex_size == 0) return 8'd0;
    return 8'(whole % longint'(tex_size));
  endfunction

  function automatic grw_rsp_t cast_ray(input grw_req_t r);
    grw_rsp_t        o;
    longint          cx, cy, ix, iy, ax, ay, nx, ny, mx, my, nmx, nmy;
    longint          ex, ey, dx, dy, hx, hy, r1, addr;
    int              ang, vo, cr;
    logic [15:0]     wall;
    logic [15:0]     map_word;
    logic [1:0]      stat;
    bit              xo, yo, inb;
    longint unsigned mxa, mya, root, dist_v;
    ang  = int'(r.ray_angle) % ANGLE_STEPS;
    vo   = int'(r.view_offset) % ANGLE_STEPS;
    cr   = (cell_res < 2) ? 2 : int'(cell_res);
    r1   = longint'(cr - 1) << 16;
    ix   = cos_q16[ang];
    iy   = sin_q16[ang];
    cx   = longint'(r.start_x);
    cy   = longint'(r.start_y);
    mx   = longint'(r.start_map_x);
    my   = longint'(r.start_map_y);
    ax   = 0;
    ay   = 0;
    hx   = 0;
    hy   = 0;
    wall = '0;
    stat = STAT_LIMIT;
    for (int n = 0; n < MAX_STEPS; n++) begin
      nx = cx + ix;
      ny = cy + iy;
      xo = (nx < 0) || (nx > r1);
      yo = (ny < 0) || (ny > r1);
      if (!xo && !yo) begin
        ax = ax + ix;
        ay = ay + iy;
        cx = nx;
        cy = ny;
        continue;
      end
      nmx = mx;
      nmy = my;
      ex  = 0;
      ey  = 0;
      dx  = 0;
      dy  = 0;
      if (xo) begin
        if (nx < 0) begin
          nx = nx + r1; nmx = nmx - 1; ex = cx; dx = r1 - nx;
        end else begin
          nx = nx - r1; nmx = nmx + 1; ex = r1 - cx; dx = nx;
        end
      end
      if (yo) begin
        if (ny < 0) begin
          ny = ny + r1; nmy = nmy - 1; ey = cy; dy = r1 - ny;
        end else begin
          ny = ny - r1; nmy = nmy + 1; ey = r1 - cy; dy = ny;
        end
      end
      inb  = (nmx >= 0) && (nmx < longint'(map_w)) && (nmy >= 0) && (nmy < MAP_SIDE);
      addr = inb ? nmx + nmy * longint'(map_w) : 0;
      if (!inb || addr >= MAP_DEPTH) begin
        ax   = ax + (xo ? ex : ix);
        ay   = ay + (yo ? ey : iy);
        stat = STAT_LEFT;
        break;
      end
      map_word = map_mem[addr];
      if (map_word == 0) begin
        mx = nmx;
        my = nmy;
        ax = ax + (xo ? dx + ex : ix);
        ay = ay + (yo ? dy + ey : iy);
        cx = nx;
        cy = ny;
      end else begin
        ax   = ax + (xo ? ex : ix);
        ay   = ay + (yo ? ey : iy);
        wall = map_word;
        hx   = nmx;
        hy   = nmy;
        stat = STAT_WALL;
        break;
      end
    end
    mxa = mag(ax) >> 8;
    mya = mag(ay) >> 8;
    if (mxa > (64'd1 << 30)) mxa = 64'd1 << 30;
    if (mya > (64'd1 << 30)) mya = 64'd1 << 30;
    root   = int_sqrt(mxa * mxa + mya * mya);
    dist_v = (root * mag(cos_q16[vo]) + 64'd32768) >> 16;
    if (dist_v > 64'hFFFFFF) dist_v = 64'hFFFFFF;
    o.column_out = r.column;
    o.wall_value = wall;
    o.distance   = 24'(dist_v);
    o.hit_map_x  = 6'(hx);
    o.hit_map_y  = 6'(hy);
    o.last_map_x = 6'(mx);
    o.last_map_y = 6'(my);
    o.texel_x    = texel_of(ax, longint'(r.start_x));
    o.texel_y    = texel_of(ay, longint'(r.start_y));
    o.status     = stat;
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic check_field(input string what, input longint got, input longint want);
    if (got != want) report(what, got, want);
  endtask

  initial begin
    longint y, y2, st, ct, s, c, s2, c2;
    for (int d = 0; d < ANGLE_STEPS; d++) begin
      y  = ((longint'(d) * 314) * (longint'(1) << 30) + 72000) / 144000;
      y2 = q30_mul(y, y);
      st = y;
      ct = longint'(1) << 30;
      s  = 0;
      c  = 0;
      for (int k = 0; k < 9; k++) begin
        if (k % 2) begin
          s = s - st; c = c - ct;
        end else begin
          s = s + st; c = c + ct;
        end
        st = q30_mul(st, y2) / longint'((2 * k + 2) * (2 * k + 3));
        ct = q30_mul(ct, y2) / longint'((2 * k + 1) * (2 * k + 2));
      end
      for (int k = 0; k < 3; k++) begin
        s2 = 2 * q30_mul(s, c);
        c2 = q30_mul(c, c) - q30_mul(s, s);
        s  = s2;
        c  = c2;
      end
      cos_q16[d] = (c < 0) ? -longint'((mag(c) + 8192) >> 14) : longint'((mag(c) + 8192) >> 14);
      sin_q16[d] = (s < 0) ? -longint'((mag(s) + 8192) >> 14) : longint'((mag(s) + 8192) >> 14);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    grw_rsp_t want;
    if (!rst_ni) begin
      cell_res <= 9'd64;
      map_w    <= 7'd64;
      tex_size <= 9'd64;
      fails    <= 0;
      ray_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CELL_RES: cell_res <= cfg_data_i;
          CFG_MAP_W:    map_w    <= cfg_data_i[6:0];
          CFG_TEX_SIZE: tex_size <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_req_i.func == FUNC_WRITE) begin
          map_mem[in_req_i.map_addr] = in_req_i.map_value;
        end else begin
          ray_results.push_back(cast_ray(in_req_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (ray_results.size() == 0) begin
          report("unexpected result", longint'(out_rsp_i), 0);
        end else begin
          want = ray_results.pop_front();
          check_field("column_out", out_rsp_i.column_out, want.column_out);
          check_field("wall_value", out_rsp_i.wall_value, want.wall_value);
          check_field("distance",   out_rsp_i.distance,   want.distance);
          check_field("hit_map_x",  out_rsp_i.hit_map_x,  want.hit_map_x);
          check_field("hit_map_y",  out_rsp_i.hit_map_y,  want.hit_map_y);
          check_field("last_map_x", out_rsp_i.last_map_x, want.last_map_x);
          check_field("last_map_y", out_rsp_i.last_map_y, want.last_map_y);
          check_field("texel_x",    out_rsp_i.texel_x,    want.texel_x);
          check_field("texel_y",    out_rsp_i.texel_y,    want.texel_y);
          check_field("status",     out_rsp_i.status,     want.status);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/grid_ray_walker_unit_tb.sv
// ---------------------------------------------------------------------------
// Grid ray walker testbench
// Fills the map words that rays reach at map widths up to 16, runs directed
// rays (axis angles, wrapped angles, edge starts, step limit, leaving the map)
// and then random mixes of map writes and rays over several register
// settings, with random idling on both channels. The checker predicts and
// compares; this module gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_ray_walker_unit_tb;
  import grw_pkg::*;

  localparam int CYCLE_LIMIT = 40000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  grw_req_t   in_req_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  grw_rsp_t   out_rsp_o;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_CELL_RES;
  logic [8:0] cfg_data_i = '0;
  int         fail_count;
  int         pending;
  bit         calm = 1'b0;
  int         cycles = 0;
  int         cur_res = 64;

  always #4 clk_i = ~clk_i;

  grid_ray_walker_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i, .out_valid_o,
    .out_ready_i, .out_rsp_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  grid_ray_walker_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_rsp_i(out_rsp_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 33);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push(input grw_req_t r);
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic map_write(input int addr, input int value);
    grw_req_t r;
    r           = grw_req_t'({$urandom, $urandom, $urandom});
    r.func      = FUNC_WRITE;
    r.map_addr  = 12'(addr);
    r.map_value = 16'(value);
    push(r);
  endtask

  task automatic cast(input int sx, input int sy, input int mx, input int my,
                      input int ang, input int vo, input int col);
    grw_req_t r;
    r             = grw_req_t'({$urandom, $urandom, $urandom});
    r.func        = FUNC_CAST;
    r.start_x     = 24'(sx);
    r.start_y     = 24'(sy);
    r.start_map_x = 6'(mx);
    r.start_map_y = 6'(my);
    r.ray_angle   = 9'(ang);
    r.view_offset = 9'(vo);
    r.column      = 12'(col);
    push(r);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_regs(input int res, input int width, input int tex);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CELL_RES;
    cfg_data_i <= 9'(res);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAP_W;
    cfg_data_i <= 9'(width);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TEX_SIZE;
    cfg_data_i <= 9'(tex);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    cur_res = res;
  endtask

  function automatic int wall_word();
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 65535);
  endfunction

  task automatic random_item;
    int sx, sy;
    if ($urandom_range(0, 99) < 25) begin
      map_write($urandom_range(0, 1023), wall_word());
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        sx = $urandom_range(0, 24'hFFFFFF);
        sy = $urandom_range(0, 24'hFFFFFF);
      end else begin
        sx = $urandom_range(0, ((cur_res - 1) << 16));
        sy = $urandom_range(0, ((cur_res - 1) << 16));
      end
      cast(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63),
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 359),
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 89),
           $urandom_range(0, 4095));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int a = 0; a < 1024; a++) begin
      map_write(a, (a[3:0] == 0 || a[9:4] == 63) ? 16'hFFFF : wall_word());
    end
    for (int a = 10 * 16; a < 11 * 16; a++) map_write(a, 0);

    set_regs(64, 16, 64);
    cast(0, 0, 5, 5, 0, 0, 0);
    cast(24'hFFFFFF, 24'hFFFFFF, 63, 63, 90, 90, 4095);
    cast(32 << 16, 32 << 16, 0, 0, 180, 359, 1);
    cast(63 << 16, 0, 62, 0, 270, 180, 2);
    cast(100, 200, 30, 30, 359, 300, 3);
    cast(1 << 16, 1 << 16, 20, 20, 400, 511, 4);
    cast(5 << 16, 7 << 16, 40, 12, 511, 45, 5);
    cast(0, 32 << 16, 1, 10, 180, 0, 6);
    cast(24'hFFFFFF, 0, 33, 33, 45, 0, 7);
    set_regs(256, 16, 256);
    cast(0, 128 << 16, 1, 10, 0, 0, 8);
    cast(0, 128 << 16, 2, 10, 0, 10, 9);
    set_regs(2, 1, 1);
    cast(0, 0, 0, 10, 180, 0, 10);
    cast(1 << 16, 1 << 16, 0, 20, 90, 0, 11);
    cast(0, 0, 0, 0, 225, 0, 12);

    set_regs(64, 16, 64);
    for (int i = 0; i < 150; i++) random_item();
    set_regs(2, 1, 1);
    for (int i = 0; i < 150; i++) random_item();
    set_regs(256, 16, 256);
    for (int i = 0; i < 50; i++) random_item();
    set_regs(3, 11, 7);
    calm = 1'b1;
    for (int i = 0; i < 200; i++) random_item();
    calm = 1'b0;
    set_regs($urandom_range(2, 40), $urandom_range(1, 16), $urandom_range(1, 256));
    for (int i = 0; i < 150; i++) random_item();
    set_regs(16, 16, 255);
    for (int i = 0; i < 150; i++) random_item();

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
